@@ hw/rtl/arqrx_pkg.sv @@
package arqrx_pkg;

   localparam int unsigned DATA_HEADER_BYTES = 4;
   localparam int unsigned INIT_HEADER_BYTES = 12;
   localparam int unsigned BUFFER_BYTES      = 65536;

   localparam int unsigned SEQ_W    = 32;
   localparam int unsigned BYTES_W  = 17;
   localparam int unsigned NAME_W   = 16;
   localparam int unsigned STATUS_W = 3;

   localparam logic [BYTES_W-1:0] DATA_HDR     = BYTES_W'(DATA_HEADER_BYTES);
   localparam logic [BYTES_W-1:0] INIT_HDR     = BYTES_W'(INIT_HEADER_BYTES);
   localparam logic [BYTES_W-1:0] BUF_MAX      = BYTES_W'(BUFFER_BYTES);
   localparam logic [BYTES_W-1:0] CREDIT_MIN   = BYTES_W'(1);
   localparam logic [SEQ_W-1:0]   SEQ_ALL_ONES = '1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPTED    = 3'd0,
      ST_DUPLICATE   = 3'd1,
      ST_FUTURE      = 3'd2,
      ST_MALFORMED   = 3'd3,
      ST_FINAL_REACK = 3'd4,
      ST_TIMEOUT     = 3'd5,
      ST_IGNORED     = 3'd6
   } status_type;

   typedef struct packed {
      logic                 is_timeout;
      logic                 is_start;
      logic                 bad_start;
      logic                 short_data;
      logic [BYTES_W-1:0]   packet_bytes;
      logic [SEQ_W-1:0]     seq_num;
      logic [SEQ_W-1:0]     file_length;
      logic [BYTES_W-1:0]   payload;
      logic [BYTES_W-1:0]   record;
      logic [SEQ_W:0]       end_sum;
   } cmd_type;

   typedef struct packed {
      logic               send_ack;
      logic [SEQ_W-1:0]   ack_number;
      logic [BYTES_W-1:0] credit;
      logic               flush;
      logic [BYTES_W-1:0] flush_bytes;
      status_type         status;
   } rsp_type;

   function automatic logic [BYTES_W-1:0] sat17(input logic [BYTES_W:0] v);
      return v[BYTES_W] ? {BYTES_W{1'b1}} : v[BYTES_W-1:0];
   endfunction

   function automatic logic [BYTES_W-1:0] sub0(input logic [BYTES_W-1:0] a,
                                                input logic [BYTES_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

endpackage

@@ hw/rtl/arqrx_front.sv @@
module arqrx_front (
   input  logic                             kind,
   input  logic [arqrx_pkg::SEQ_W-1:0]      seq_num,
   input  logic [arqrx_pkg::BYTES_W-1:0]    packet_bytes,
   input  logic [arqrx_pkg::SEQ_W-1:0]      file_length,
   input  logic [arqrx_pkg::NAME_W-1:0]     name_length,
   output arqrx_pkg::cmd_type               cmd
);

   logic [arqrx_pkg::BYTES_W-1:0] init_left;
   logic [arqrx_pkg::BYTES_W-1:0] name_ext;

   always_comb begin
      init_left = packet_bytes - arqrx_pkg::INIT_HDR;
      name_ext  = arqrx_pkg::BYTES_W'(name_length);

      cmd.is_timeout   = kind;
      cmd.is_start     = (seq_num == '0);
      cmd.bad_start    = (packet_bytes < arqrx_pkg::INIT_HDR) || (name_ext > init_left);
      cmd.short_data   = (packet_bytes < arqrx_pkg::DATA_HDR);
      cmd.packet_bytes = packet_bytes;
      cmd.seq_num      = seq_num;
      cmd.file_length  = file_length;
      if (cmd.is_start) begin
         cmd.payload = init_left - name_ext;
      end else begin
         cmd.payload = packet_bytes - arqrx_pkg::DATA_HDR;
      end
      cmd.record  = cmd.payload + arqrx_pkg::DATA_HDR;
      cmd.end_sum = {1'b0, seq_num} + (arqrx_pkg::SEQ_W + 1)'(cmd.payload);
   end

endmodule

@@ hw/rtl/arqrx_cmd_fifo.sv @@
module arqrx_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  arqrx_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output arqrx_pkg::cmd_type pop_data,
   output logic               empty
);

   arqrx_pkg::cmd_type entries_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("command queue count out of range");

   a_pop_guard: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("command queue popped while empty");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers disagree with count");

endmodule

@@ hw/rtl/arqrx_back.sv @@
module arqrx_back (
   input  logic                          clock,
   input  logic                          reset,
   input  arqrx_pkg::cmd_type            cmd,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   input  logic                          csr_write_enable,
   input  logic [arqrx_pkg::BYTES_W-1:0] csr_write_data,
   output arqrx_pkg::rsp_type            rsp,
   output logic                          empty,
   input  logic                          pop
);

   localparam int unsigned BW = arqrx_pkg::BYTES_W;
   localparam int unsigned SW = arqrx_pkg::SEQ_W;

   logic [SW-1:0] expected_byte_ff, expected_byte_in;
   logic [SW-1:0] final_ack_ff, final_ack_in;
   logic [SW-1:0] session_length_ff, session_length_in;
   logic          idle_ff, idle_in;
   logic [BW-1:0] free_credit_ff, free_credit_in;
   logic [BW-1:0] buffered_total_ff, buffered_total_in;
   logic [BW-1:0] buffered_payload_ff, buffered_payload_in;

   arqrx_pkg::rsp_type out_ff [2];
   logic               out_wr_ff, out_wr_in;
   logic               out_rd_ff, out_rd_in;
   logic [1:0]         out_count_ff, out_count_in;
   logic               out_full, out_pop;

   arqrx_pkg::rsp_type res;
   logic               take;
   logic               accept;
   logic [BW-1:0]      free_b, btot_b, bpay_b;
   logic [SW-1:0]      sess_b, final_b;
   logic               idle_b;
   logic [BW-1:0]      btot2, free2, bpay2;
   logic [SW-1:0]      pay2, exp2;
   logic [SW:0]        bpay_sum;
   logic               do_final, do_flush;
   logic [BW-1:0]      eff_credit;

   assign out_full = (out_count_ff == 2'd2);
   assign empty    = (out_count_ff == 2'd0);
   assign rsp      = out_ff[out_rd_ff];
   assign out_pop  = pop && !empty;
   assign take     = !cmd_empty && !out_full;
   assign cmd_pop  = take;

   always_comb begin
      expected_byte_in    = expected_byte_ff;
      final_ack_in        = final_ack_ff;
      session_length_in   = session_length_ff;
      idle_in             = idle_ff;
      free_credit_in      = free_credit_ff;
      buffered_total_in   = buffered_total_ff;
      buffered_payload_in = buffered_payload_ff;

      res.send_ack    = 1'b0;
      res.ack_number  = '0;
      res.flush       = 1'b0;
      res.flush_bytes = '0;
      res.status      = arqrx_pkg::ST_IGNORED;

      accept  = 1'b0;
      free_b  = free_credit_ff;
      btot_b  = buffered_total_ff;
      bpay_b  = buffered_payload_ff;
      sess_b  = session_length_ff;
      final_b = final_ack_ff;
      idle_b  = idle_ff;

      if (cmd.is_timeout) begin
         if (!idle_ff) begin
            res.flush           = 1'b1;
            res.flush_bytes     = buffered_payload_ff;
            free_credit_in      = arqrx_pkg::sat17({1'b0, free_credit_ff} +
                                                   {1'b0, buffered_total_ff});
            buffered_total_in   = '0;
            buffered_payload_in = '0;
            idle_in             = 1'b1;
            expected_byte_in    = '0;
            final_ack_in        = arqrx_pkg::SEQ_ALL_ONES;
            res.status          = arqrx_pkg::ST_TIMEOUT;
         end
      end else if (cmd.packet_bytes > free_credit_ff) begin
         res.status = arqrx_pkg::ST_IGNORED;
      end else if (cmd.is_start) begin
         if (cmd.bad_start) begin
            res.status = arqrx_pkg::ST_MALFORMED;
         end else begin
            accept  = 1'b1;
            free_b  = arqrx_pkg::sat17({1'b0, free_credit_ff} + {1'b0, buffered_total_ff});
            btot_b  = '0;
            bpay_b  = '0;
            sess_b  = cmd.file_length;
            final_b = arqrx_pkg::SEQ_ALL_ONES;
            idle_b  = 1'b0;
         end
      end else if (cmd.short_data) begin
         res.status = arqrx_pkg::ST_IGNORED;
      end else if (idle_ff && (cmd.end_sum == {1'b0, final_ack_ff})) begin
         res.status     = arqrx_pkg::ST_FINAL_REACK;
         res.send_ack   = 1'b1;
         res.ack_number = final_ack_ff;
      end else if (cmd.seq_num < expected_byte_ff) begin
         res.status     = arqrx_pkg::ST_DUPLICATE;
         res.send_ack   = 1'b1;
         res.ack_number = expected_byte_ff;
      end else if (cmd.seq_num > expected_byte_ff) begin
         res.status = arqrx_pkg::ST_FUTURE;
      end else begin
         accept = 1'b1;
      end

      btot2 = arqrx_pkg::sat17({1'b0, btot_b} + {1'b0, cmd.record});
      free2 = arqrx_pkg::sub0(free_b, cmd.record);
      if (cmd.end_sum > {1'b0, sess_b}) begin
         pay2 = SW'(cmd.payload) - (cmd.end_sum[SW-1:0] - sess_b);
         exp2 = sess_b;
      end else begin
         pay2 = SW'(cmd.payload);
         exp2 = cmd.end_sum[SW-1:0];
      end
      bpay_sum = (SW + 1)'(bpay_b) + {1'b0, pay2};
      bpay2    = (|bpay_sum[SW:BW]) ? {BW{1'b1}} : bpay_sum[BW-1:0];
      do_final = (exp2 == sess_b);
      do_flush = (SW'(free2) < pay2) || do_final;

      if (accept) begin
         res.status        = arqrx_pkg::ST_ACCEPTED;
         res.send_ack      = 1'b1;
         res.ack_number    = exp2;
         session_length_in = sess_b;
         expected_byte_in  = exp2;
         final_ack_in      = final_b;
         idle_in           = idle_b;
         if (do_flush) begin
            res.flush           = 1'b1;
            res.flush_bytes     = bpay2;
            free_credit_in      = arqrx_pkg::sat17({1'b0, free2} + {1'b0, btot2});
            buffered_total_in   = '0;
            buffered_payload_in = '0;
         end else begin
            free_credit_in      = free2;
            buffered_total_in   = btot2;
            buffered_payload_in = bpay2;
         end
         if (do_final) begin
            idle_in          = 1'b1;
            final_ack_in     = sess_b;
            expected_byte_in = '0;
         end
      end

      res.credit = free_credit_in;
   end

   always_comb begin
      if (csr_write_data == '0) begin
         eff_credit = arqrx_pkg::CREDIT_MIN;
      end else if (csr_write_data > arqrx_pkg::BUF_MAX) begin
         eff_credit = arqrx_pkg::BUF_MAX;
      end else begin
         eff_credit = csr_write_data;
      end
      out_wr_in    = take ? !out_wr_ff : out_wr_ff;
      out_rd_in    = out_pop ? !out_rd_ff : out_rd_ff;
      out_count_in = out_count_ff + 2'(take) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_byte_ff    <= '0;
         final_ack_ff        <= arqrx_pkg::SEQ_ALL_ONES;
         session_length_ff   <= '0;
         idle_ff             <= 1'b1;
         free_credit_ff      <= arqrx_pkg::BUF_MAX;
         buffered_total_ff   <= '0;
         buffered_payload_ff <= '0;
         out_wr_ff           <= 1'b0;
         out_rd_ff           <= 1'b0;
         out_count_ff        <= 2'd0;
      end else begin
         if (take) begin
            expected_byte_ff    <= expected_byte_in;
            final_ack_ff        <= final_ack_in;
            session_length_ff   <= session_length_in;
            idle_ff             <= idle_in;
            buffered_total_ff   <= buffered_total_in;
            buffered_payload_ff <= buffered_payload_in;
         end
         if (csr_write_enable) begin
            free_credit_ff <= arqrx_pkg::sub0(eff_credit, buffered_total_ff);
         end else if (take) begin
            free_credit_ff <= free_credit_in;
         end
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff[out_wr_ff] <= res;
      end
   end

   a_expected_within_session: assert property (@(posedge clock) disable iff (reset)
      expected_byte_ff <= session_length_ff)
      else $error("expected byte beyond session length");

   a_idle_buffer_empty: assert property (@(posedge clock) disable iff (reset)
      idle_ff |-> (buffered_total_ff == '0 && buffered_payload_ff == '0))
      else $error("buffer holds data while idle");

   a_timeout_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (take && res.status == arqrx_pkg::ST_TIMEOUT) |=> (idle_ff && expected_byte_ff == '0))
      else $error("timeout did not reset the session");

   a_payload_within_total: assert property (@(posedge clock) disable iff (reset)
      buffered_payload_ff <= buffered_total_ff)
      else $error("buffered payload exceeds buffered total");

endmodule

@@ hw/rtl/arq_receiver_with_credit_top.sv @@
// A beat passes the command queue, then the back-end state update, then the result queue.
// Throughput: one beat per cycle while the result queue is not full.
// Two-entry queues sit between front and back and at the result side.
// Reset is synchronous: both queues empty, session idle, credit 65536, final ack all ones.
// No clearing pass follows reset; the block takes beats on the next cycle.
module arq_receiver_with_credit_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_kind,
   input  logic [arqrx_pkg::SEQ_W-1:0]   req_seq_num,
   input  logic [arqrx_pkg::BYTES_W-1:0] req_packet_bytes,
   input  logic [arqrx_pkg::SEQ_W-1:0]   req_file_length,
   input  logic [arqrx_pkg::NAME_W-1:0]  req_name_length,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_send_ack,
   output logic [arqrx_pkg::SEQ_W-1:0]   rsp_ack_number,
   output logic [arqrx_pkg::BYTES_W-1:0] rsp_credit,
   output logic                          rsp_flush,
   output logic [arqrx_pkg::BYTES_W-1:0] rsp_flush_bytes,
   output logic [arqrx_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          csr_write_enable,
   input  logic [arqrx_pkg::BYTES_W-1:0] csr_write_data
);

   arqrx_pkg::cmd_type front_cmd;
   arqrx_pkg::cmd_type head_cmd;
   arqrx_pkg::rsp_type rsp;
   logic               cmd_empty;
   logic               cmd_pop;

   arqrx_front u_front (
      .kind         (req_kind),
      .seq_num      (req_seq_num),
      .packet_bytes (req_packet_bytes),
      .file_length  (req_file_length),
      .name_length  (req_name_length),
      .cmd          (front_cmd)
   );

   arqrx_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (head_cmd),
      .empty     (cmd_empty)
   );

   arqrx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (head_cmd),
      .cmd_empty        (cmd_empty),
      .cmd_pop          (cmd_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (rsp),
      .empty            (empty),
      .pop              (pop)
   );

   assign rsp_send_ack    = rsp.send_ack;
   assign rsp_ack_number  = rsp.ack_number;
   assign rsp_credit      = rsp.credit;
   assign rsp_flush       = rsp.flush;
   assign rsp_flush_bytes = rsp.flush_bytes;
   assign rsp_status      = rsp.status;

endmodule

@@ bench/testbench.sv @@
module testbench;

   localparam int unsigned CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic                          kind;
      logic [arqrx_pkg::SEQ_W-1:0]   seq_num;
      logic [arqrx_pkg::BYTES_W-1:0] packet_bytes;
      logic [arqrx_pkg::SEQ_W-1:0]   file_length;
      logic [arqrx_pkg::NAME_W-1:0]  name_length;
   } datagram_type;

   class arq_scoreboard_type;
      logic [arqrx_pkg::BYTES_W-1:0] credit_setting;
      logic [arqrx_pkg::SEQ_W-1:0]   expected_byte;
      logic [arqrx_pkg::SEQ_W-1:0]   final_ack;
      logic [arqrx_pkg::SEQ_W-1:0]   session_length;
      logic                          idle;
      logic [arqrx_pkg::BYTES_W-1:0] free_credit;
      logic [arqrx_pkg::BYTES_W-1:0] buffered_total;
      logic [arqrx_pkg::BYTES_W-1:0] buffered_payload;
      arqrx_pkg::rsp_type            due[$];
      int                            errors;
      int                            checked;
      int                            noted;
      int                            by_status[8];

      function new();
         credit_setting   = arqrx_pkg::BUF_MAX;
         expected_byte    = '0;
         final_ack        = arqrx_pkg::SEQ_ALL_ONES;
         session_length   = '0;
         idle             = 1'b1;
         buffered_total   = '0;
         buffered_payload = '0;
         free_credit      = window();
      endfunction

      function logic [arqrx_pkg::BYTES_W-1:0] clip17(logic [63:0] v);
         return (v > 64'h1FFFF) ? '1 : v[arqrx_pkg::BYTES_W-1:0];
      endfunction

      function logic [arqrx_pkg::BYTES_W-1:0] floor0(logic [arqrx_pkg::BYTES_W-1:0] a,
                                                     logic [arqrx_pkg::BYTES_W-1:0] b);
         return (a > b) ? a - b : '0;
      endfunction

      function logic [arqrx_pkg::BYTES_W-1:0] window();
         if (credit_setting == '0) return arqrx_pkg::CREDIT_MIN;
         if (credit_setting > arqrx_pkg::BUF_MAX) return arqrx_pkg::BUF_MAX;
         return credit_setting;
      endfunction

      function void write_credit(logic [arqrx_pkg::BYTES_W-1:0] value);
         credit_setting = value;
         free_credit    = floor0(window(), buffered_total);
      endfunction

      function void drain_buffer(inout logic [arqrx_pkg::BYTES_W-1:0] written);
         written          = clip17(64'(written) + 64'(buffered_payload));
         free_credit      = clip17(64'(free_credit) + 64'(buffered_total));
         buffered_total   = '0;
         buffered_payload = '0;
      endfunction

      function void note_datagram(datagram_type d);
         logic [63:0]                   pb;
         logic [63:0]                   pay;
         logic [63:0]                   end_sum;
         logic [63:0]                   rec;
         logic [arqrx_pkg::BYTES_W-1:0] written;
         logic                          flushed;
         logic                          send;
         logic [arqrx_pkg::SEQ_W-1:0]   ack;
         arqrx_pkg::status_type         st;
         arqrx_pkg::rsp_type            r;
         pb      = 64'(d.packet_bytes);
         pay     = '0;
         written = '0;
         flushed = 1'b0;
         send    = 1'b0;
         ack     = '0;
         st      = arqrx_pkg::ST_IGNORED;
         if (d.kind) begin
            if (!idle) begin
               drain_buffer(written);
               flushed       = 1'b1;
               idle          = 1'b1;
               expected_byte = '0;
               final_ack     = arqrx_pkg::SEQ_ALL_ONES;
               st            = arqrx_pkg::ST_TIMEOUT;
            end
         end else if (pb > 64'(free_credit)) begin
            st = arqrx_pkg::ST_IGNORED;
         end else if (d.seq_num == '0) begin
            if (pb < 64'(arqrx_pkg::INIT_HEADER_BYTES) ||
                64'(d.name_length) > pb - 64'(arqrx_pkg::INIT_HEADER_BYTES)) begin
               st = arqrx_pkg::ST_MALFORMED;
            end else begin
               // drop the old session's buffer, return its space
               free_credit      = clip17(64'(free_credit) + 64'(buffered_total));
               buffered_total   = '0;
               buffered_payload = '0;
               expected_byte    = '0;
               final_ack        = arqrx_pkg::SEQ_ALL_ONES;
               session_length   = d.file_length;
               idle             = 1'b0;
               pay              = pb - 64'(arqrx_pkg::INIT_HEADER_BYTES) - 64'(d.name_length);
               st               = arqrx_pkg::ST_ACCEPTED;
            end
         end else if (pb < 64'(arqrx_pkg::DATA_HEADER_BYTES)) begin
            st = arqrx_pkg::ST_IGNORED;
         end else begin
            pay = pb - 64'(arqrx_pkg::DATA_HEADER_BYTES);
            if (idle && 64'(d.seq_num) + pay == 64'(final_ack)) begin
               st   = arqrx_pkg::ST_FINAL_REACK;
               send = 1'b1;
               ack  = final_ack;
            end else if (d.seq_num < expected_byte) begin
               st   = arqrx_pkg::ST_DUPLICATE;
               send = 1'b1;
               ack  = expected_byte;
            end else if (d.seq_num > expected_byte) begin
               st = arqrx_pkg::ST_FUTURE;
            end else begin
               st = arqrx_pkg::ST_ACCEPTED;
            end
         end
         if (st == arqrx_pkg::ST_ACCEPTED) begin
            end_sum        = 64'(d.seq_num) + pay;
            rec            = 64'(clip17(pay + 64'(arqrx_pkg::DATA_HEADER_BYTES)));
            buffered_total = clip17(64'(buffered_total) + rec);
            free_credit    = floor0(free_credit, rec[arqrx_pkg::BYTES_W-1:0]);
            if (end_sum > 64'(session_length)) begin
               pay     = pay - (end_sum - 64'(session_length));
               end_sum = 64'(session_length);
            end
            expected_byte    = end_sum[arqrx_pkg::SEQ_W-1:0];
            ack              = expected_byte;
            send             = 1'b1;
            buffered_payload = clip17(64'(buffered_payload) + pay);
            if (64'(free_credit) < pay) begin
               drain_buffer(written);
               flushed = 1'b1;
            end
            if (expected_byte == session_length) begin
               drain_buffer(written);
               flushed       = 1'b1;
               idle          = 1'b1;
               final_ack     = session_length;
               expected_byte = '0;
            end
         end
         r.send_ack    = send;
         r.ack_number  = send ? ack : '0;
         r.credit      = free_credit;
         r.flush       = flushed;
         r.flush_bytes = flushed ? written : '0;
         r.status      = st;
         due.push_back(r);
         noted++;
         by_status[st]++;
      endfunction

      function void check_response(arqrx_pkg::rsp_type got);
         arqrx_pkg::rsp_type want;
         checked++;
         if (due.size() == 0) begin
            $error("response with nothing outstanding, status %0d", got.status);
            errors++;
         end else begin
            want = due.pop_front();
            if (got.send_ack !== want.send_ack) begin
               $error("send_ack: expected %0d, actual %0d", want.send_ack, got.send_ack);
               errors++;
            end
            if (got.ack_number !== want.ack_number) begin
               $error("ack_number: expected %0d, actual %0d", want.ack_number, got.ack_number);
               errors++;
            end
            if (got.credit !== want.credit) begin
               $error("credit: expected %0d, actual %0d", want.credit, got.credit);
               errors++;
            end
            if (got.flush !== want.flush) begin
               $error("flush: expected %0d, actual %0d", want.flush, got.flush);
               errors++;
            end
            if (got.flush_bytes !== want.flush_bytes) begin
               $error("flush_bytes: expected %0d, actual %0d", want.flush_bytes,
                      got.flush_bytes);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, got.status);
               errors++;
            end
         end
      endfunction
   endclass

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            push             = 1'b0;
   logic                            pop              = 1'b0;
   logic                            req_kind         = 1'b0;
   logic [arqrx_pkg::SEQ_W-1:0]     req_seq_num      = '0;
   logic [arqrx_pkg::BYTES_W-1:0]   req_packet_bytes = '0;
   logic [arqrx_pkg::SEQ_W-1:0]     req_file_length  = '0;
   logic [arqrx_pkg::NAME_W-1:0]    req_name_length  = '0;
   logic                            csr_write_enable = 1'b0;
   logic [arqrx_pkg::BYTES_W-1:0]   csr_write_data   = '0;
   logic                            full;
   logic                            empty;
   logic                            rsp_send_ack;
   logic [arqrx_pkg::SEQ_W-1:0]     rsp_ack_number;
   logic [arqrx_pkg::BYTES_W-1:0]   rsp_credit;
   logic                            rsp_flush;
   logic [arqrx_pkg::BYTES_W-1:0]   rsp_flush_bytes;
   logic [arqrx_pkg::STATUS_W-1:0]  rsp_status;

   arq_scoreboard_type tracker;
   arqrx_pkg::rsp_type seen;
   int unsigned        send_gap_pct     = 36;
   int unsigned        take_gap_pct     = 78;
   int unsigned        cycle_count      = 0;
   int unsigned        settings_written = 0;

   arq_receiver_with_credit_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_kind         (req_kind),
      .req_seq_num      (req_seq_num),
      .req_packet_bytes (req_packet_bytes),
      .req_file_length  (req_file_length),
      .req_name_length  (req_name_length),
      .empty            (empty),
      .pop              (pop),
      .rsp_send_ack     (rsp_send_ack),
      .rsp_ack_number   (rsp_ack_number),
      .rsp_credit       (rsp_credit),
      .rsp_flush        (rsp_flush),
      .rsp_flush_bytes  (rsp_flush_bytes),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            seen.send_ack    = rsp_send_ack;
            seen.ack_number  = rsp_ack_number;
            seen.credit      = rsp_credit;
            seen.flush       = rsp_flush;
            seen.flush_bytes = rsp_flush_bytes;
            seen.status      = arqrx_pkg::status_type'(rsp_status);
            tracker.check_response(seen);
         end
         pop <= ($urandom_range(99) >= take_gap_pct);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("arq_receiver_with_credit_top verification failed");
      $finish;
   end

   function automatic datagram_type make_dg(logic kind, logic [arqrx_pkg::SEQ_W-1:0] seq,
                                            logic [arqrx_pkg::BYTES_W-1:0] pbytes,
                                            logic [arqrx_pkg::SEQ_W-1:0] flen,
                                            logic [arqrx_pkg::NAME_W-1:0] nlen);
      datagram_type d;
      d.kind         = kind;
      d.seq_num      = seq;
      d.packet_bytes = pbytes;
      d.file_length  = flen;
      d.name_length  = nlen;
      return d;
   endfunction

   function automatic datagram_type compose();
      datagram_type d;
      int unsigned  pick;
      int unsigned  room;
      int unsigned  span;
      int unsigned  nlen_cap;
      int unsigned  pay;
      logic [63:0]  left;
      d.kind         = 1'b0;
      d.seq_num      = '0;
      d.packet_bytes = '0;
      d.file_length  = $urandom();
      d.name_length  = '0;
      room = 32'(tracker.free_credit);
      pick = $urandom_range(99);
      span = (room < 600) ? room : 600;
      if (span < arqrx_pkg::DATA_HEADER_BYTES) span = arqrx_pkg::DATA_HEADER_BYTES;
      if (pick < 12) begin
         d.kind         = ($urandom_range(9) == 0);
         d.seq_num      = ($urandom_range(3) == 0) ? '0 : $urandom();
         d.packet_bytes = 17'($urandom_range(arqrx_pkg::BUFFER_BYTES));
         d.name_length  = 16'($urandom());
      end else if (pick < 16) begin
         d.kind = 1'b1;
      end else if (pick < 24) begin
         d.seq_num      = tracker.expected_byte + 32'd1 + $urandom_range(5000);
         d.packet_bytes = 17'($urandom_range(arqrx_pkg::DATA_HEADER_BYTES, span));
      end else if (pick < 34) begin
         d.packet_bytes = 17'($urandom_range(arqrx_pkg::DATA_HEADER_BYTES, span));
         if (tracker.idle)
            d.seq_num = tracker.final_ack -
                        (32'(d.packet_bytes) - arqrx_pkg::DATA_HEADER_BYTES);
         else if (tracker.expected_byte > 1)
            d.seq_num = $urandom_range(1, tracker.expected_byte - 1);
         else
            d.seq_num = 32'd1;
      end else if (tracker.idle || tracker.expected_byte == '0 || $urandom_range(14) == 0) begin
         if (room < arqrx_pkg::INIT_HEADER_BYTES) begin
            d.packet_bytes = 17'(room);
         end else begin
            case ($urandom_range(9))
               0:       d.file_length = '0;
               1:       d.file_length = $urandom();
               default: d.file_length = $urandom_range(1, 4000);
            endcase
            nlen_cap = room - arqrx_pkg::INIT_HEADER_BYTES;
            if (nlen_cap > 40) nlen_cap = 40;
            d.name_length = 16'($urandom_range(nlen_cap));
            span = room - arqrx_pkg::INIT_HEADER_BYTES - 32'(d.name_length);
            if ($urandom_range(9) != 0 && span > 300) span = 300;
            d.packet_bytes = 17'(arqrx_pkg::INIT_HEADER_BYTES + 32'(d.name_length) +
                                 $urandom_range(span));
         end
      end else begin
         d.seq_num = tracker.expected_byte;
         if (room < arqrx_pkg::DATA_HEADER_BYTES) begin
            d.packet_bytes = 17'(arqrx_pkg::DATA_HEADER_BYTES);
         end else begin
            left = 64'(tracker.session_length) - 64'(tracker.expected_byte);
            span = room - arqrx_pkg::DATA_HEADER_BYTES;
            if ($urandom_range(3) == 0 && left <= 64'(span))
               pay = 32'(left);
            else if ($urandom_range(7) == 0)
               pay = $urandom_range(span);
            else
               pay = $urandom_range((span < 400) ? span : 400);
            d.packet_bytes = 17'(arqrx_pkg::DATA_HEADER_BYTES + pay);
         end
      end
      return d;
   endfunction

   task automatic offer(input datagram_type d);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      push             <= 1'b1;
      req_kind         <= d.kind;
      req_seq_num      <= d.seq_num;
      req_packet_bytes <= d.packet_bytes;
      req_file_length  <= d.file_length;
      req_name_length  <= d.name_length;
      do @(posedge clock); while (full);
      tracker.note_datagram(d);
   endtask

   task automatic settle();
      push <= 1'b0;
      do @(posedge clock); while (tracker.due.size() != 0);
   endtask

   task automatic set_credit(input logic [arqrx_pkg::BYTES_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.write_credit(value);
      settings_written++;
   endtask

   initial begin
      datagram_type                  plan[$];
      logic [arqrx_pkg::BYTES_W-1:0] credit_plan[10];
      logic [arqrx_pkg::BYTES_W-1:0] value;
      int                            burst;
      tracker     = new();
      credit_plan = '{17'h10000, 17'd4000, 17'd1, 17'd300, 17'h1FFFF,
                      17'd40, 17'd0, 17'd1500, 17'd65535, 17'd12};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(make_dg(1'b1, '0, '0, '0, '0));
      plan.push_back(make_dg(1'b0, arqrx_pkg::SEQ_ALL_ONES - 32'd100, 17'd104, '0, '0));
      plan.push_back(make_dg(1'b0, '0, 17'd11, 32'd50, '0));
      plan.push_back(make_dg(1'b0, '0, 17'd20, 32'd50, 16'd9));
      plan.push_back(make_dg(1'b0, '0, 17'h10000, arqrx_pkg::SEQ_ALL_ONES, 16'hFFFF));
      plan.push_back(make_dg(1'b0, '0, 17'h10000, arqrx_pkg::SEQ_ALL_ONES, '0));
      plan.push_back(make_dg(1'b0, 32'd1, 17'd4, '0, '0));
      plan.push_back(make_dg(1'b0, 32'd70000, 17'd10, '0, '0));
      plan.push_back(make_dg(1'b0, 32'd65524, 17'd3, '0, '0));
      plan.push_back(make_dg(1'b1, '0, '0, '0, '0));
      plan.push_back(make_dg(1'b0, '0, 17'd19, 32'd10, 16'd2));
      plan.push_back(make_dg(1'b0, 32'd5, 17'd24, '0, '0));
      plan.push_back(make_dg(1'b0, 32'd5, 17'd9, '0, '0));
      plan.push_back(make_dg(1'b0, arqrx_pkg::SEQ_ALL_ONES, 17'd15, '0, '0));
      plan.push_back(make_dg(1'b0, '0, 17'd12, '0, '0));
      plan.push_back(make_dg(1'b0, '0, 17'd500, 32'd1000, '0));
      plan.push_back(make_dg(1'b0, 32'd488, 17'h10000, '0, '0));
      plan.push_back(make_dg(1'b0, '0, 17'd30, 32'd50, 16'd4));
      plan.push_back(make_dg(1'b0, 32'd14, 17'd20, '0, '0));
      plan.push_back(make_dg(1'b1, '0, '0, '0, '0));
      foreach (plan[i]) offer(plan[i]);

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 36 : (phase == 1) ? 78 : 0;
         take_gap_pct = (phase == 0) ? 78 : (phase == 1) ? 36 : 0;
         for (int blk = 0; blk < 6; blk++) begin
            if (blk == 5)
               value = 17'($urandom_range(2, 70000));
            else
               value = credit_plan[(phase * 6 + blk) % 10];
            set_credit(value);
            burst = (tracker.window() < 12) ? 12 : 68;
            for (int n = 0; n < burst; n++) begin
               // hold until every response is back
               if (n == burst / 2 && blk == 1) settle();
               offer(compose());
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("%0d beats sent over %0d credit settings, %0d responses compared",
               tracker.noted, settings_written, tracker.checked);
      $display("accepted %0d dup %0d future %0d malformed %0d re-ack %0d timeout %0d ign %0d",
               tracker.by_status[arqrx_pkg::ST_ACCEPTED],
               tracker.by_status[arqrx_pkg::ST_DUPLICATE],
               tracker.by_status[arqrx_pkg::ST_FUTURE],
               tracker.by_status[arqrx_pkg::ST_MALFORMED],
               tracker.by_status[arqrx_pkg::ST_FINAL_REACK],
               tracker.by_status[arqrx_pkg::ST_TIMEOUT],
               tracker.by_status[arqrx_pkg::ST_IGNORED]);
      if (tracker.errors == 0 && tracker.due.size() == 0)
         $display("arq_receiver_with_credit_top verification clean");
      else
         $display("arq_receiver_with_credit_top verification failed");
      $finish;
   end

endmodule
